### rtl/sdtq_pkg.sv
// Package for the sorted deadline timer queue.
// Holds field widths, default sizes, operation and status codes and the slot command type.
// It depends on nothing else.
package sdtq_pkg;

  localparam int DL_W            = 64;
  localparam int TID_W           = 8;
  localparam int OP_W            = 2;
  localparam int STATUS_W        = 3;
  localparam int IN_TDATA_W      = 136;
  localparam int OUT_TDATA_W     = 80;
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_ID_BITS     = 8;
  localparam int MAX_RESULTS     = 16;
  localparam int FIRE_CNT_W      = $clog2(MAX_RESULTS);

  localparam logic [OP_W-1:0] OP_ARM    = 2'd0;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
  localparam logic [OP_W-1:0] OP_PARK   = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_ARMED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_READY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUP       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_FIRED     = 3'd6;
  localparam logic [STATUS_W-1:0] ST_NOTHING   = 3'd7;

  typedef enum logic [1:0] {
    SLOT_HOLD   = 2'd0,
    SLOT_INSERT = 2'd1,
    SLOT_REMOVE = 2'd2,
    SLOT_POP    = 2'd3
  } slot_op_t;

  typedef struct packed {
    slot_op_t          op;
    logic [DL_W-1:0]   key_dl;
    logic [TID_W-1:0]  key_id;
  } slot_cmd_t;

endpackage

### rtl/sdtq_slot.sv
// One slot of the sorted timer chain: holds a deadline and an id.
// It compares against the broadcast key and moves data to or from its neighbours.
// Depends on sdtq_pkg.
module sdtq_slot #(
  parameter int ID_W = sdtq_pkg::DEF_ID_BITS
) (
  input  logic                      clk,
  input  sdtq_pkg::slot_cmd_t       cmd_i,
  input  logic                      occ_i,
  input  logic                      prev_le_i,
  input  logic                      past_i,
  input  logic [sdtq_pkg::DL_W-1:0] left_dl_i,
  input  logic [ID_W-1:0]           left_id_i,
  input  logic [sdtq_pkg::DL_W-1:0] right_dl_i,
  input  logic [ID_W-1:0]           right_id_i,
  output logic [sdtq_pkg::DL_W-1:0] dl_o,
  output logic [ID_W-1:0]           id_o,
  output logic                      le_o,
  output logic                      hit_o
);

  logic [sdtq_pkg::DL_W-1:0] dl_r;
  logic [sdtq_pkg::DL_W-1:0] dl_nxt;
  logic [ID_W-1:0]           id_r;
  logic [ID_W-1:0]           id_nxt;

  assign le_o  = occ_i && (dl_r <= cmd_i.key_dl);
  assign hit_o = occ_i && (id_r == cmd_i.key_id[ID_W-1:0]);
  assign dl_o  = dl_r;
  assign id_o  = id_r;

  always_comb begin
    dl_nxt = dl_r;
    id_nxt = id_r;
    case (cmd_i.op)
      sdtq_pkg::SLOT_INSERT: begin
        if (!le_o) begin
          if (prev_le_i) begin
            dl_nxt = cmd_i.key_dl;
            id_nxt = cmd_i.key_id[ID_W-1:0];
          end else begin
            dl_nxt = left_dl_i;
            id_nxt = left_id_i;
          end
        end
      end
      sdtq_pkg::SLOT_REMOVE: begin
        if (past_i) begin
          dl_nxt = right_dl_i;
          id_nxt = right_id_i;
        end
      end
      sdtq_pkg::SLOT_POP: begin
        dl_nxt = right_dl_i;
        id_nxt = right_id_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    dl_r <= dl_nxt;
    id_r <= id_nxt;
  end

endmodule

### rtl/sorted_deadline_timer_queue_top.sv
// Sorted deadline timer queue: a chain of slots kept in ascending deadline order,
// with arm, cancel and park operations. An arm, a cancel or a park with nothing pending
// gives its single result from the execute state once the output side is free; a park
// that finds timers goes through the execute and evaluate states and then gives one
// result per cycle from the fire state while the output side accepts, one slot chain
// shift per fired timer. A new input transfer is taken in the cycle after the last result
// of the previous one has been registered, while that result may still wait for the
// output side.
// Depends on sdtq_pkg and sdtq_slot.
module sorted_deadline_timer_queue_top #(
  parameter int QUEUE_DEPTH = sdtq_pkg::DEF_QUEUE_DEPTH,
  parameter int ID_BITS     = sdtq_pkg::DEF_ID_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // timer_id [7:0], duration [71:8], now_time [135:72]
  input  logic [sdtq_pkg::IN_TDATA_W-1:0]   in_tdata,
  // opcode [1:0]
  input  logic [sdtq_pkg::OP_W-1:0]         in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // fired_id [7:0], effective_time [71:8], idle [72], zero padding [79:73]
  output logic [sdtq_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // status [2:0]
  output logic [sdtq_pkg::STATUS_W-1:0]     out_tuser,
  output logic                              out_tlast
);

  localparam int IdW  = (ID_BITS < sdtq_pkg::TID_W) ? ID_BITS : sdtq_pkg::TID_W;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int DlW  = sdtq_pkg::DL_W;
  localparam int TidW = sdtq_pkg::TID_W;
  localparam int FcW  = sdtq_pkg::FIRE_CNT_W;
  localparam int PadW = sdtq_pkg::OUT_TDATA_W - TidW - DlW - 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_EVAL = 4'b0100,
    S_FIRE = 4'b1000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CntW-1:0]              count_r, count_nxt;
  logic [FcW-1:0]               fire_cnt_r, fire_cnt_nxt;
  logic [sdtq_pkg::OP_W-1:0]    op_r;
  logic [TidW-1:0]              id_r;
  logic [DlW-1:0]               dl_r;
  logic [DlW-1:0]               now_r;
  logic [DlW-1:0]               eff_r, eff_nxt;
  logic                         idle_r, idle_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [sdtq_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [TidW-1:0]              out_id_r, out_id_nxt;
  logic [DlW-1:0]               out_eff_r, out_eff_nxt;
  logic                         out_idle_r, out_idle_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_load;
  logic                         out_free;

  sdtq_pkg::slot_cmd_t          cmd;
  logic [QUEUE_DEPTH-1:0]       occ;
  logic [QUEUE_DEPTH-1:0]       le_vec;
  logic [QUEUE_DEPTH-1:0]       hit_vec;
  logic [QUEUE_DEPTH-1:0]       past_vec;
  logic [QUEUE_DEPTH-1:0]       prev_le;
  logic [DlW-1:0]               slot_dl [QUEUE_DEPTH];
  logic [IdW-1:0]               slot_id [QUEUE_DEPTH];
  logic                         found;
  logic                         fire_last;
  logic [sdtq_pkg::STATUS_W-1:0] arm_status;

  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign found     = |hit_vec;
  assign fire_last = !le_vec[1] || (fire_cnt_r == FcW'(sdtq_pkg::MAX_RESULTS - 1));

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_chain
      localparam logic [QUEUE_DEPTH-1:0] UpToMask = {QUEUE_DEPTH{1'b1}} >> (QUEUE_DEPTH - 1 - g);
      logic [DlW-1:0] left_dl;
      logic [IdW-1:0] left_id;
      logic [DlW-1:0] right_dl;
      logic [IdW-1:0] right_id;

      assign occ[g]      = (count_r > CntW'(g));
      assign past_vec[g] = |(hit_vec & UpToMask);

      if (g == 0) begin : g_head
        assign prev_le[g] = 1'b1;
        assign left_dl    = slot_dl[g];
        assign left_id    = slot_id[g];
      end else begin : g_body
        assign prev_le[g] = le_vec[g-1];
        assign left_dl    = slot_dl[g-1];
        assign left_id    = slot_id[g-1];
      end

      if (g == QUEUE_DEPTH - 1) begin : g_tail
        assign right_dl = slot_dl[g];
        assign right_id = slot_id[g];
      end else begin : g_inner
        assign right_dl = slot_dl[g+1];
        assign right_id = slot_id[g+1];
      end

      sdtq_slot #(
        .ID_W (IdW)
      ) u_slot (
        .clk        (clk),
        .cmd_i      (cmd),
        .occ_i      (occ[g]),
        .prev_le_i  (prev_le[g]),
        .past_i     (past_vec[g]),
        .left_dl_i  (left_dl),
        .left_id_i  (left_id),
        .right_dl_i (right_dl),
        .right_id_i (right_id),
        .dl_o       (slot_dl[g]),
        .id_o       (slot_id[g]),
        .le_o       (le_vec[g]),
        .hit_o      (hit_vec[g])
      );
    end
  endgenerate

  always_comb begin
    if (dl_r <= now_r) begin
      arm_status = sdtq_pkg::ST_READY;
    end else if (found) begin
      arm_status = sdtq_pkg::ST_DUP;
    end else if (count_r == CntW'(QUEUE_DEPTH)) begin
      arm_status = sdtq_pkg::ST_FULL;
    end else begin
      arm_status = sdtq_pkg::ST_ARMED;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    fire_cnt_nxt   = fire_cnt_r;
    eff_nxt        = eff_r;
    idle_nxt       = idle_r;
    out_load       = 1'b0;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_eff_nxt    = out_eff_r;
    out_idle_nxt   = out_idle_r;
    out_last_nxt   = out_last_r;
    cmd.op         = sdtq_pkg::SLOT_HOLD;
    cmd.key_dl     = (state_r == S_EXEC) ? dl_r : eff_r;
    cmd.key_id     = id_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (op_r == sdtq_pkg::OP_UNUSED) begin
          state_nxt = S_IDLE;
        end else if (op_r == sdtq_pkg::OP_PARK && count_r != '0) begin
          eff_nxt      = (slot_dl[0] > now_r) ? slot_dl[0] : now_r;
          fire_cnt_nxt = '0;
          state_nxt    = S_EVAL;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_id_nxt   = '0;
          out_eff_nxt  = now_r;
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
          if (op_r == sdtq_pkg::OP_ARM) begin
            out_status_nxt = arm_status;
            if (arm_status == sdtq_pkg::ST_ARMED) begin
              cmd.op       = sdtq_pkg::SLOT_INSERT;
              count_nxt    = count_r + 1'b1;
              out_idle_nxt = 1'b0;
            end else begin
              out_idle_nxt = (count_r == '0);
            end
          end else if (op_r == sdtq_pkg::OP_CANCEL) begin
            if (found) begin
              cmd.op         = sdtq_pkg::SLOT_REMOVE;
              count_nxt      = count_r - 1'b1;
              out_status_nxt = sdtq_pkg::ST_CANCELLED;
              out_idle_nxt   = (count_r == CntW'(1));
            end else begin
              out_status_nxt = sdtq_pkg::ST_NOTFOUND;
              out_idle_nxt   = (count_r == '0);
            end
          end else begin
            out_status_nxt = sdtq_pkg::ST_NOTHING;
            out_idle_nxt   = 1'b1;
          end
        end
      end
      S_EVAL: begin
        idle_nxt  = (le_vec == occ) && (32'(count_r) <= sdtq_pkg::MAX_RESULTS);
        state_nxt = S_FIRE;
      end
      S_FIRE: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = sdtq_pkg::ST_FIRED;
          out_id_nxt     = TidW'(slot_id[0]);
          out_eff_nxt    = eff_r;
          out_idle_nxt   = idle_r;
          out_last_nxt   = fire_last;
          cmd.op         = sdtq_pkg::SLOT_POP;
          count_nxt      = count_r - 1'b1;
          fire_cnt_nxt   = fire_cnt_r + 1'b1;
          if (fire_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      fire_cnt_r  <= '0;
      eff_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      fire_cnt_r  <= fire_cnt_nxt;
      eff_r       <= eff_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r  <= in_tuser;
      id_r  <= TidW'(in_tdata[IdW-1:0]);
      dl_r  <= in_tdata[135:72] + in_tdata[71:8];
      now_r <= in_tdata[135:72];
    end
    idle_r       <= idle_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_eff_r    <= out_eff_nxt;
    out_idle_r   <= out_idle_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{PadW{1'b0}}, out_idle_r, out_eff_r, out_id_r};

  // The occupancy count never goes beyond the number of slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= QUEUE_DEPTH)
    else $error("pending count exceeds the queue depth");

  // Ids held in the queue are unique, so at most one slot can match a key.
  a_unique_id: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("more than one slot holds the same id");

  // The chain stays sorted: a slot at or before the key implies all earlier ones are too.
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    ((le_vec >> 1) & ~le_vec) == '0)
    else $error("slot chain is out of deadline order");

  // While firing, the head slot is occupied and due.
  a_head_due: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIRE) |-> (occ[0] && le_vec[0]))
    else $error("firing with no due timer at the head");

  // The final fired result returns the block to idle.
  a_fire_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIRE && out_free && fire_last) |=> (state_r == S_IDLE))
    else $error("park did not finish after its last result");

endmodule

### tb/sv/sdtq_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the sorted deadline timer queue testbench: a predictor of the timer list
// and a store of the results it expects. Depends on sdtq_pkg.
package sdtq_tb_pkg;
  import sdtq_pkg::*;

  typedef struct packed {
    logic [DL_W-1:0]  deadline;
    logic [TID_W-1:0] id;
  } timer_entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TID_W-1:0]    fired_id;
    logic [DL_W-1:0]     eff_time;
    logic                idle;
    logic                last;
  } timer_result_t;

  class timer_queue_scoreboard;
    timer_entry_t  timers[$];
    timer_result_t expected[$];
    int unsigned   mismatches = 0;

    task report(string what);
      mismatches++;
      if (mismatches <= 40) $display("%0t mismatch: %s", $realtime, what);
    endtask

    function int find_timer(logic [TID_W-1:0] tid);
      for (int i = 0; i < timers.size(); i++) begin
        if (timers[i].id == tid) return i;
      end
      return -1;
    endfunction

    function void note_input(logic [OP_W-1:0] op, logic [TID_W-1:0] tid,
                             logic [DL_W-1:0] dur, logic [DL_W-1:0] now);
      timer_result_t step_res[$];
      timer_result_t res;
      timer_entry_t  ent;
      logic [TID_W-1:0] key;
      logic [DL_W-1:0]  dl;
      logic [DL_W-1:0]  eff;
      int pos;
      key = tid & TID_W'((1 << DEF_ID_BITS) - 1);
      res = '{status: ST_ARMED, fired_id: '0, eff_time: now, idle: 1'b0, last: 1'b1};
      if (op == OP_ARM) begin
        dl = now + dur;
        if (dl <= now) begin
          res.status = ST_READY;
        end else if (find_timer(key) >= 0) begin
          res.status = ST_DUP;
        end else if (timers.size() >= DEF_QUEUE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < timers.size() && timers[pos].deadline <= dl) pos++;
          ent = '{deadline: dl, id: key};
          timers.insert(pos, ent);
        end
        step_res.push_back(res);
      end else if (op == OP_CANCEL) begin
        pos = find_timer(key);
        if (pos >= 0) begin
          timers.delete(pos);
          res.status = ST_CANCELLED;
        end else begin
          res.status = ST_NOTFOUND;
        end
        step_res.push_back(res);
      end else if (op == OP_PARK) begin
        if (timers.size() == 0) begin
          res.status = ST_NOTHING;
          step_res.push_back(res);
        end else begin
          eff = (timers[0].deadline > now) ? timers[0].deadline : now;
          while (timers.size() > 0 && step_res.size() < MAX_RESULTS &&
                 timers[0].deadline <= eff) begin
            res = '{status: ST_FIRED, fired_id: timers[0].id, eff_time: eff,
                    idle: 1'b0, last: 1'b0};
            step_res.push_back(res);
            void'(timers.pop_front());
          end
          step_res[step_res.size() - 1].last = 1'b1;
        end
      end
      foreach (step_res[k]) begin
        step_res[k].idle = (timers.size() == 0);
        expected.push_back(step_res[k]);
      end
    endfunction

    task check_result(timer_result_t got);
      timer_result_t want;
      if (expected.size() == 0) begin
        report($sformatf("result with status %0d arrived with nothing expected", got.status));
      end else begin
        want = expected.pop_front();
        if (got.status !== want.status)
          report($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.fired_id !== want.fired_id)
          report($sformatf("fired_id %0h, expected %0h", got.fired_id, want.fired_id));
        if (got.eff_time !== want.eff_time)
          report($sformatf("effective_time %0h, expected %0h", got.eff_time, want.eff_time));
        if (got.idle !== want.idle)
          report($sformatf("idle %0b, expected %0b", got.idle, want.idle));
        if (got.last !== want.last)
          report($sformatf("last %0b, expected %0b", got.last, want.last));
      end
    endtask
  endclass

endpackage

### tb/sv/tb_sorted_deadline_timer_queue_top.sv
`timescale 1ns / 100ps
// Testbench for sorted_deadline_timer_queue_top: directed and random arm, cancel and park
// transfers with random gaps and stalls, each result checked against the scoreboard.
// Depends on sdtq_pkg, sdtq_tb_pkg and the block itself.
module tb_sorted_deadline_timer_queue_top;
  import sdtq_pkg::*;
  import sdtq_tb_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 250;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [OP_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0] out_tuser;
  logic out_tlast;

  bit no_gaps = 1'b0;
  bit hold_off_req = 1'b0;
  int unsigned cycle_count = 0;
  timer_queue_scoreboard sb = new();
  timer_result_t seen;

  always #4 clk = ~clk;

  sorted_deadline_timer_queue_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [TID_W-1:0] tid,
                           input logic [DL_W-1:0] dur, input logic [DL_W-1:0] now);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {now, dur, tid};
    in_tuser <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(op, tid, dur, now);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen = '{status: out_tuser, fired_id: out_tdata[7:0], eff_time: out_tdata[71:8],
               idle: out_tdata[72], last: out_tlast};
      sb.check_result(seen);
    end
  end

  // Result side: bursts of readiness broken by stalls, and one long hold-off on request.
  initial begin
    int len;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end
      out_tready <= 1'b1;
      len = $urandom_range(1, 24);
      repeat (len) @(posedge clk);
      len = pick_gap();
      if (len > 0) begin
        out_tready <= 1'b0;
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_sorted_deadline_timer_queue_top failed");
    $finish;
  end

  initial begin
    logic [DL_W-1:0] cur_now;
    logic [DL_W-1:0] r_dur;
    logic [DL_W-1:0] r_now;
    logic [TID_W-1:0] r_id;
    logic [OP_W-1:0] r_op;
    int counted;
    int roll;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_item(OP_PARK, 8'h00, 64'd0, 64'd0);
    send_item(OP_ARM, 8'h3C, 64'd0, 64'd5);
    send_item(OP_ARM, 8'hC3, '1, 64'd1);
    send_item(OP_CANCEL, 8'h5A, 64'd0, 64'd7);
    send_item(OP_UNUSED, 8'hFF, '1, '1);
    // Sixteen arms fill the queue; durations come in equal pairs to test arrival order.
    for (int i = 0; i < 16; i++)
      send_item(OP_ARM, 8'(i * 17), 64'(((i * 5) % 8 + 1) * 10), 64'd1000);
    send_item(OP_ARM, 8'h77, 64'd1, 64'd1000);
    send_item(OP_ARM, 8'h80, 64'd1, 64'd1000);
    send_item(OP_CANCEL, 8'h77, 64'd0, 64'd1010);
    send_item(OP_PARK, 8'h00, 64'd0, 64'd0);
    send_item(OP_PARK, 8'h00, 64'd0, '1);
    send_item(OP_CANCEL, 8'hFF, 64'd0, '1);

    cur_now = 64'd2000;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted == 60) hold_off_req = 1'b1;
      no_gaps = (counted >= 120 && counted < 170);
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        r_op = OP_W'($urandom_range(0, 3));
        r_id = TID_W'($urandom);
        r_dur = {$urandom, $urandom};
        r_now = {$urandom, $urandom};
      end else begin
        cur_now = cur_now + $urandom_range(0, 60);
        if ($urandom_range(0, 49) == 0) cur_now = {$urandom, $urandom};
        roll = $urandom_range(0, 99);
        r_op = (roll < 50) ? OP_ARM : (roll < 68) ? OP_CANCEL :
               (roll < 96) ? OP_PARK : OP_UNUSED;
        r_id = TID_W'($urandom_range(0, 19) * 13);
        roll = $urandom_range(0, 99);
        if (roll < 8) r_dur = '0;
        else if (roll < 12) r_dur = {$urandom, $urandom};
        else r_dur = 64'($urandom_range(1, 400));
        r_now = cur_now;
      end
      send_item(r_op, r_id, r_dur, r_now);
      if (r_op != OP_UNUSED) counted++;
    end
    in_tvalid <= 1'b0;
    no_gaps = 1'b0;

    while (sb.expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb_sorted_deadline_timer_queue_top passed");
    end else begin
      $display("tb_sorted_deadline_timer_queue_top failed");
    end
    $finish;
  end

endmodule

### sorted_deadline_timer_queue_top.f
rtl/sdtq_pkg.sv
rtl/sdtq_slot.sv
rtl/sorted_deadline_timer_queue_top.sv
tb/sv/sdtq_tb_pkg.sv
tb/sv/tb_sorted_deadline_timer_queue_top.sv
